/* rtl/edat_pkg.sv */
// Shared types and constants for the encoder detent and acceleration tracker.
`default_nettype none

package edat_pkg;

   localparam int DATA_W               = 32;
   localparam int EDGES_PER_DETENT_DEF = 4;
   localparam int SLOW_US              = 120000;
   localparam int FAST_US              = 25000;
   localparam int SPAN_US              = SLOW_US - FAST_US;
   localparam int PER_W                = 17;
   localparam int MULT_W               = 4;
   localparam int REQ_DATA_W           = 104;
   localparam int RSP_DATA_W           = 80;
   localparam int CSR_ADDR_W           = 1;
   localparam int CSR_DATA_W           = 4;

   localparam logic [1:0] DIR_NONE = 2'b00;
   localparam logic [1:0] DIR_CW   = 2'b01;
   localparam logic [1:0] DIR_CCW  = 2'b11;

   typedef enum logic [1:0] {
      ACT_POLL = 2'd0,
      ACT_SET  = 2'd1,
      ACT_READ = 2'd2,
      ACT_NONE = 2'd3
   } action_type;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_ACCEL_ENABLE = 1'b0,
      CSR_ACCEL_MAX    = 1'b1
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DETENT,
      ST_STEP,
      ST_SCALE,
      ST_APPLY,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

endpackage

`default_nettype wire

/* rtl/edat_div.sv */
// Radix-4 digit-serial unsigned divider, two quotient bits per cycle.
`default_nettype none

module edat_div import edat_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [DATA_W-1:0] dividend,
   input  logic [DATA_W-1:0] divisor,
   output logic [DATA_W-1:0] quot,
   output logic [DATA_W-1:0] rem,
   output div_stat_type      stat
);

   localparam int STEPS = DATA_W / 2;
   localparam int CNT_W = $clog2(STEPS);

   logic [DATA_W-1:0] quo_ff, quo_in;
   logic [DATA_W-1:0] rem_ff, rem_in;
   logic [DATA_W-1:0] dsr_ff, dsr_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;

   logic [DATA_W+1:0] shifted, d1, d2, d3, diff;
   logic [1:0]        digit;

   always_comb begin
      shifted = {rem_ff, quo_ff[DATA_W-1 -: 2]};
      d1      = {2'b00, dsr_ff};
      d2      = {1'b0, dsr_ff, 1'b0};
      d3      = d1 + d2;
      // pick the largest multiple of the divisor that fits
      if (shifted >= d3) begin
         digit = 2'd3;
         diff  = shifted - d3;
      end else if (shifted >= d2) begin
         digit = 2'd2;
         diff  = shifted - d2;
      end else if (shifted >= d1) begin
         digit = 2'd1;
         diff  = shifted - d1;
      end else begin
         digit = 2'd0;
         diff  = shifted;
      end

      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;

      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         dsr_in  = divisor;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         quo_in = {quo_ff[DATA_W-3:0], digit};
         rem_in = diff[DATA_W-1:0];
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign quot      = quo_ff;
   assign rem       = rem_ff;
   assign stat.busy = busy_ff;
   assign stat.done = done_ff;

endmodule

`default_nettype wire

/* rtl/encoder_detent_accel_tracker_top.sv */
// Top level of the rotary encoder detent, position and acceleration tracker.
// Read and no-op go straight to the response; set position and polls divide the edge
// count into detents, polls with motion divide elapsed time by the detent delta, and a
// third divide runs when the multiplier falls in the linear band. One transaction in
// flight; the next request is taken in the cycle the response is presented.
// Synchronous active-high reset clears tracking state, sets accel_enable 1, max mult 5.
`default_nettype none

module encoder_detent_accel_tracker_top import edat_pkg::*; #(
   parameter int EDGES_PER_DETENT = EDGES_PER_DETENT_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   // request stream
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // edge_count[31:0], time_us[63:32], button_down[64], new_position[96:65], zero pad
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // action[1:0]
   input  logic [1:0]            req_tuser,
   // response stream
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // position[31:0], raw_position[63:32], direction[65:64], turned_cw[66],
   // turned_ccw[67], press_seen[68], applied_mult[72:69], zero pad
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   // configuration writes
   input  logic                  csr_we,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   // ---------------------------------------------------------------------------------
   // Request field unpacking
   // ---------------------------------------------------------------------------------
   logic [DATA_W-1:0] req_edge, req_time, req_newpos, req_edge_abs;
   logic              req_button, req_accept;
   action_type        req_action;

   assign req_edge     = req_tdata[31:0];
   assign req_time     = req_tdata[63:32];
   assign req_button   = req_tdata[64];
   assign req_newpos   = req_tdata[96:65];
   assign req_action   = action_type'(req_tuser);
   assign req_edge_abs = req_edge[DATA_W-1] ? (DATA_W'(0) - req_edge) : req_edge;
   assign req_accept   = req_tvalid && req_tready;

   // ---------------------------------------------------------------------------------
   // Registers
   // ---------------------------------------------------------------------------------
   state_type         state_ff, state_in;
   action_type        action_ff, action_in;
   logic              edge_neg_ff, edge_neg_in;
   logic [DATA_W-1:0] time_ff, time_in;
   logic              button_ff, button_in;
   logic [DATA_W-1:0] newpos_ff, newpos_in;
   logic [DATA_W-1:0] detent_ff, detent_in;
   logic [DATA_W-1:0] delta_ff, delta_in;
   logic [MULT_W-1:0] mult_ff, mult_in;

   // tracking state
   logic [DATA_W-1:0] baseline_ff, baseline_in;
   logic [DATA_W-1:0] accel_pos_ff, accel_pos_in;
   logic [DATA_W-1:0] detent_pos_ff, detent_pos_in;
   logic [1:0]        last_dir_ff, last_dir_in;
   logic              cw_ff, cw_in;
   logic              ccw_ff, ccw_in;
   logic [DATA_W-1:0] last_time_ff, last_time_in;
   logic              prev_btn_ff, prev_btn_in;
   logic              press_ff, press_in;

   // configuration
   logic              accel_en_ff, accel_en_in;
   logic [MULT_W-1:0] max_mult_ff, max_mult_in;

   // response holding register
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   // ---------------------------------------------------------------------------------
   // Shared divider
   // ---------------------------------------------------------------------------------
   logic              div_start;
   logic [DATA_W-1:0] div_dividend, div_divisor, div_quot, div_rem;
   div_stat_type      div_stat;

   edat_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .quot     (div_quot),
      .rem      (div_rem),
      .stat     (div_stat)
   );

   // ---------------------------------------------------------------------------------
   // Datapath terms
   // ---------------------------------------------------------------------------------
   logic [DATA_W-1:0] det_up, detent_val, delta_val, delta_mag, elapsed, step_term;
   logic              delta_neg;
   logic [MULT_W-1:0] max_eff, max_m1;
   logic [PER_W-1:0]  per_off;
   logic [DATA_W-1:0] scale_prod;
   logic              per_ge_slow, per_le_fast;
   logic              press_new, rsp_load;

   // floor division: a negative count rounds away from zero when a remainder is left
   assign det_up     = div_quot + DATA_W'(|div_rem);
   assign detent_val = edge_neg_ff ? (DATA_W'(0) - det_up) : div_quot;
   assign delta_val  = detent_val - baseline_ff;
   assign delta_neg  = delta_val[DATA_W-1];
   assign delta_mag  = delta_neg ? (DATA_W'(0) - delta_val) : delta_val;
   assign elapsed    = time_ff - last_time_ff;

   // a maximum of zero behaves as one
   assign max_eff     = (max_mult_ff == '0) ? MULT_W'(1) : max_mult_ff;
   assign max_m1      = max_eff - MULT_W'(1);
   assign per_ge_slow = div_quot >= DATA_W'(SLOW_US);
   assign per_le_fast = div_quot <= DATA_W'(FAST_US);
   // per-step time lies strictly inside the band here, so 17 bits hold it
   assign per_off     = div_quot[PER_W-1:0] - PER_W'(FAST_US);
   assign scale_prod  = DATA_W'(per_off) * DATA_W'(max_m1);

   assign step_term = delta_ff * DATA_W'(mult_ff);
   assign press_new = press_ff | (button_ff & ~prev_btn_ff);
   assign rsp_load  = (state_ff == ST_FINISH) && (!rsp_valid_ff || rsp_tready);

   // ---------------------------------------------------------------------------------
   // Sequencer: next state, datapath updates and divider launches
   // ---------------------------------------------------------------------------------
   always_comb begin
      state_in      = state_ff;
      action_in     = action_ff;
      edge_neg_in   = edge_neg_ff;
      time_in       = time_ff;
      button_in     = button_ff;
      newpos_in     = newpos_ff;
      detent_in     = detent_ff;
      delta_in      = delta_ff;
      mult_in       = mult_ff;
      baseline_in   = baseline_ff;
      accel_pos_in  = accel_pos_ff;
      detent_pos_in = detent_pos_ff;
      last_dir_in   = last_dir_ff;
      cw_in         = cw_ff;
      ccw_in        = ccw_ff;
      last_time_in  = last_time_ff;
      prev_btn_in   = prev_btn_ff;
      press_in      = press_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_data_in   = rsp_data_ff;
      div_start     = 1'b0;
      div_dividend  = req_edge_abs;
      div_divisor   = DATA_W'(EDGES_PER_DETENT);
      req_tready    = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               action_in   = req_action;
               edge_neg_in = req_edge[DATA_W-1];
               time_in     = req_time;
               button_in   = req_button;
               newpos_in   = req_newpos;
               mult_in     = '0;
               // poll and set position both need the count in detents
               if (req_action == ACT_POLL || req_action == ACT_SET) begin
                  div_start = 1'b1;
                  state_in  = ST_DETENT;
               end else begin
                  state_in  = ST_FINISH;
               end
            end
         end

         ST_DETENT: begin
            if (div_stat.done) begin
               if (action_ff == ACT_SET) begin
                  accel_pos_in  = newpos_ff;
                  detent_pos_in = newpos_ff;
                  baseline_in   = detent_val;
                  state_in      = ST_FINISH;
               end else if (delta_val == '0) begin
                  state_in = ST_FINISH;
               end else begin
                  // time per detent: elapsed over the detent magnitude
                  detent_in    = detent_val;
                  delta_in     = delta_val;
                  div_start    = 1'b1;
                  div_dividend = elapsed;
                  div_divisor  = delta_mag;
                  state_in     = ST_STEP;
               end
            end
         end

         ST_STEP: begin
            if (div_stat.done) begin
               if (!accel_en_ff || per_ge_slow) begin
                  mult_in  = MULT_W'(1);
                  state_in = ST_APPLY;
               end else if (per_le_fast) begin
                  mult_in  = max_eff;
                  state_in = ST_APPLY;
               end else begin
                  // linear band: scale the offset into the span
                  div_start    = 1'b1;
                  div_dividend = scale_prod;
                  div_divisor  = DATA_W'(SPAN_US);
                  state_in     = ST_SCALE;
               end
            end
         end

         ST_SCALE: begin
            if (div_stat.done) begin
               mult_in  = max_eff - div_quot[MULT_W-1:0];
               state_in = ST_APPLY;
            end
         end

         ST_APPLY: begin
            accel_pos_in  = accel_pos_ff + step_term;
            detent_pos_in = detent_pos_ff + delta_ff;
            baseline_in   = detent_ff;
            last_time_in  = time_ff;
            if (delta_ff[DATA_W-1]) begin
               last_dir_in = DIR_CCW;
               ccw_in      = 1'b1;
            end else begin
               last_dir_in = DIR_CW;
               cw_in       = 1'b1;
            end
            state_in = ST_FINISH;
         end

         ST_FINISH: begin
            // hold here until the output register is free
            if (rsp_load) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = '0;
               rsp_data_in[31:0]  = accel_pos_ff;
               rsp_data_in[63:32] = detent_pos_ff;
               rsp_data_in[65:64] = last_dir_ff;
               rsp_data_in[66]    = cw_ff;
               rsp_data_in[67]    = ccw_ff;
               rsp_data_in[68]    = press_ff;
               rsp_data_in[72:69] = mult_ff;
               if (action_ff == ACT_POLL) begin
                  rsp_data_in[68] = press_new;
                  press_in        = press_new;
                  prev_btn_in     = button_ff;
               end
               // report first, then clear the event flags
               if (action_ff == ACT_READ) begin
                  last_dir_in = DIR_NONE;
                  cw_in       = 1'b0;
                  ccw_in      = 1'b0;
                  press_in    = 1'b0;
               end
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // ---------------------------------------------------------------------------------
   // Configuration decode
   // ---------------------------------------------------------------------------------
   always_comb begin
      accel_en_in = accel_en_ff;
      max_mult_in = max_mult_ff;
      if (csr_we) begin
         unique case (csr_addr)
            CSR_ACCEL_ENABLE: accel_en_in = csr_wdata[0];
            CSR_ACCEL_MAX:    max_mult_in = csr_wdata[MULT_W-1:0];
            default: begin
               accel_en_in = accel_en_ff;
            end
         endcase
      end
   end

   // ---------------------------------------------------------------------------------
   // Register updates
   // ---------------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         baseline_ff   <= '0;
         accel_pos_ff  <= '0;
         detent_pos_ff <= '0;
         last_dir_ff   <= DIR_NONE;
         cw_ff         <= 1'b0;
         ccw_ff        <= 1'b0;
         last_time_ff  <= '0;
         prev_btn_ff   <= 1'b0;
         press_ff      <= 1'b0;
         accel_en_ff   <= 1'b1;
         max_mult_ff   <= MULT_W'(5);
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         baseline_ff   <= baseline_in;
         accel_pos_ff  <= accel_pos_in;
         detent_pos_ff <= detent_pos_in;
         last_dir_ff   <= last_dir_in;
         cw_ff         <= cw_in;
         ccw_ff        <= ccw_in;
         last_time_ff  <= last_time_in;
         prev_btn_ff   <= prev_btn_in;
         press_ff      <= press_in;
         accel_en_ff   <= accel_en_in;
         max_mult_ff   <= max_mult_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      action_ff   <= action_in;
      edge_neg_ff <= edge_neg_in;
      time_ff     <= time_in;
      button_ff   <= button_in;
      newpos_ff   <= newpos_in;
      detent_ff   <= detent_in;
      delta_ff    <= delta_in;
      mult_ff     <= mult_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // ---------------------------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------------------------
`ifndef SYNTHESIS
   // the divider only finishes while the sequencer waits on it
   a_div_done_expected: assert property (@(posedge clock) disable iff (reset)
      div_stat.done |-> (state_ff == ST_DETENT || state_ff == ST_STEP ||
                         state_ff == ST_SCALE))
      else $error("divider finished outside a wait state");

   // a new request is never taken while a divide is running
   a_idle_div_free: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> !div_stat.busy)
      else $error("request taken with divider busy");

   // motion always applies a multiplier of at least one
   a_apply_mult: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_APPLY) |-> (mult_ff != '0))
      else $error("zero multiplier applied on motion");

   // a read leaves all event flags cleared
   a_read_clears: assert property (@(posedge clock) disable iff (reset)
      (rsp_load && action_ff == ACT_READ && req_accept == 1'b0) |=>
         (!cw_ff && !ccw_ff && !press_ff && last_dir_ff == DIR_NONE))
      else $error("event flags not cleared after read");
`endif

endmodule

`default_nettype wire
